/* rtl/max_weight_monotone_chain_core_macros.svh */
// ----------------------------------------------------------------------------
// max_weight_monotone_chain_core_macros
// assertion helpers shared by the chain core modules
// ----------------------------------------------------------------------------
`ifndef MAX_WEIGHT_MONOTONE_CHAIN_CORE_MACROS_SVH
`define MAX_WEIGHT_MONOTONE_CHAIN_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MWC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MWC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mwc_pkg.sv */
// ----------------------------------------------------------------------------
// mwc_pkg
// types and constants of the maximum weight monotone chain core
// ----------------------------------------------------------------------------
`default_nettype none

package mwc_pkg;

  localparam int RowW = 16;
  localparam int ColW = 10;
  localparam int WgtW = 16;
  localparam int PosW = 10;
  localparam int TotW = 26;
  localparam int LenW = 11;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_NOT_RUN = 2'd2,
    STS_BEYOND  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PT_SEL_I   = 2'd0,
    PT_SEL_J   = 2'd1,
    PT_SEL_ORD = 2'd2
  } pt_sel_e;

  typedef enum logic {
    ORD_SEL_I     = 1'b0,
    ORD_SEL_CHAIN = 1'b1
  } ord_sel_e;

  typedef struct packed {
    op_e              op;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  column;
    logic [WgtW-1:0]  weight;
    logic [PosW-1:0]  position;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [TotW-1:0]  total_score;
    logic [LenW-1:0]  chain_length;
    logic [RowW-1:0]  point_row;
    logic [ColW-1:0]  point_column;
  } out_t;

  typedef struct packed {
    logic     load_pt;
    logic     out_load;
    status_e  out_status;
    logic     out_point;
    logic     i_clr;
    logic     i_inc;
    logic     j_clr;
    logic     j_inc;
    logic     key_latch;
    logic     rank_cmp;
    logic     pt_re;
    pt_sel_e  pt_sel;
    logic     ord_re;
    ord_sel_e ord_sel;
    logic     ord_we;
    logic     tbl_re;
    logic     tbl_clr_we;
    logic     col_clr;
    logic     col_inc;
    logic     sweep_init;
    logic     sweep_fin;
    logic     sweep_cmp;
    logic     pt_latch;
    logic     upd_we;
    logic     fin_latch;
    logic     pred_re;
    logic     walk_from_pred;
    logic     len_inc;
    logic     walk_reset;
    logic     chain_we;
    logic     chain_re;
    logic     ready_set;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic i_last;
    logic j_last;
    logic col_last;
    logic col_at_last;
    logic walk_valid;
    logic len_zero;
    logic ready;
    logic pos_beyond;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/mwc_ctrl.sv */
// ----------------------------------------------------------------------------
// mwc_ctrl
// sequencer for load, run (sort, table sweep, backtrack), chain reads and unused ops
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_weight_monotone_chain_core_macros.svh"

module mwc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  mwc_pkg::op_e     op_i,
  output logic             in_stall_o,
  input  mwc_pkg::stat_t   st_i,
  output mwc_pkg::cmd_t    cmd_o
);
  import mwc_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE     = 23'h000001,
    S_RK_A     = 23'h000002,
    S_RK_B     = 23'h000004,
    S_CMP_A    = 23'h000008,
    S_CMP_B    = 23'h000010,
    S_ORD_W    = 23'h000020,
    S_CLR      = 23'h000040,
    S_PT_A     = 23'h000080,
    S_PT_B     = 23'h000100,
    S_PT_C     = 23'h000200,
    S_BS_A     = 23'h000400,
    S_BS_B     = 23'h000800,
    S_UPD      = 23'h001000,
    S_FIN_INIT = 23'h002000,
    S_FIN      = 23'h004000,
    S_CNT_A    = 23'h008000,
    S_CNT_B    = 23'h010000,
    S_CH_A     = 23'h020000,
    S_CH_B     = 23'h040000,
    S_RUN_OUT  = 23'h080000,
    S_RD_A     = 23'h100000,
    S_RD_B     = 23'h200000,
    S_RD_C     = 23'h400000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   accept;

  assign in_stall_o = !((state_q == S_IDLE) && st_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    fin_d   = fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_LOAD: begin
              cmd_o.load_pt    = !st_i.full;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_status = st_i.full ? STS_FULL : STS_OK;
            end
            OP_RUN: begin
              cmd_o.i_clr   = 1'b1;
              cmd_o.col_clr = 1'b1;
              state_d       = st_i.cnt_zero ? S_CLR : S_RK_A;
            end
            OP_READ: begin
              if (!st_i.ready) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = STS_NOT_RUN;
              end else if (st_i.pos_beyond) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = STS_BEYOND;
              end else begin
                cmd_o.chain_re = 1'b1;
                state_d        = S_RD_A;
              end
            end
            OP_NONE: begin
              cmd_o.out_load = 1'b1;
            end
          endcase
        end
      end
      // stable rank of point i: count keys strictly before it
      S_RK_A: begin
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PT_SEL_I;
        state_d      = S_RK_B;
      end
      S_RK_B: begin
        cmd_o.key_latch = 1'b1;
        cmd_o.j_clr     = 1'b1;
        state_d         = S_CMP_A;
      end
      S_CMP_A: begin
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PT_SEL_J;
        state_d      = S_CMP_B;
      end
      S_CMP_B: begin
        cmd_o.rank_cmp = 1'b1;
        cmd_o.j_inc    = 1'b1;
        state_d        = st_i.j_last ? S_ORD_W : S_CMP_A;
      end
      S_ORD_W: begin
        cmd_o.ord_we = 1'b1;
        cmd_o.i_inc  = 1'b1;
        state_d      = st_i.i_last ? S_CLR : S_RK_A;
      end
      S_CLR: begin
        cmd_o.tbl_clr_we = 1'b1;
        cmd_o.col_inc    = 1'b1;
        if (st_i.col_last) begin
          cmd_o.i_clr = 1'b1;
          state_d     = st_i.cnt_zero ? S_FIN_INIT : S_PT_A;
        end
      end
      S_PT_A: begin
        cmd_o.ord_re  = 1'b1;
        cmd_o.ord_sel = ORD_SEL_I;
        state_d       = S_PT_B;
      end
      S_PT_B: begin
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PT_SEL_ORD;
        state_d      = S_PT_C;
      end
      S_PT_C: begin
        cmd_o.pt_latch   = 1'b1;
        cmd_o.sweep_init = 1'b1;
        fin_d            = 1'b0;
        state_d          = S_BS_A;
      end
      S_BS_A: begin
        cmd_o.tbl_re = 1'b1;
        state_d      = S_BS_B;
      end
      S_BS_B: begin
        cmd_o.sweep_cmp = 1'b1;
        if (st_i.col_at_last) begin
          state_d = fin_q ? S_FIN : S_UPD;
        end else begin
          cmd_o.col_inc = 1'b1;
          state_d       = S_BS_A;
        end
      end
      S_UPD: begin
        cmd_o.upd_we = 1'b1;
        cmd_o.i_inc  = 1'b1;
        state_d      = st_i.i_last ? S_FIN_INIT : S_PT_A;
      end
      S_FIN_INIT: begin
        cmd_o.sweep_init = 1'b1;
        cmd_o.sweep_fin  = 1'b1;
        fin_d            = 1'b1;
        state_d          = S_BS_A;
      end
      S_FIN: begin
        cmd_o.fin_latch = 1'b1;
        state_d         = S_CNT_A;
      end
      S_CNT_A: begin
        if (st_i.walk_valid) begin
          cmd_o.pred_re = 1'b1;
          cmd_o.len_inc = 1'b1;
          state_d       = S_CNT_B;
        end else begin
          cmd_o.walk_reset = 1'b1;
          state_d          = S_CH_A;
        end
      end
      S_CNT_B: begin
        cmd_o.walk_from_pred = 1'b1;
        state_d              = S_CNT_A;
      end
      // second walk fills the chain list from its tail
      S_CH_A: begin
        if (!st_i.len_zero && st_i.walk_valid) begin
          cmd_o.chain_we = 1'b1;
          cmd_o.pred_re  = 1'b1;
          state_d        = S_CH_B;
        end else begin
          state_d = S_RUN_OUT;
        end
      end
      S_CH_B: begin
        cmd_o.walk_from_pred = 1'b1;
        state_d              = S_CH_A;
      end
      S_RUN_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.ready_set = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RD_A: begin
        cmd_o.ord_re  = 1'b1;
        cmd_o.ord_sel = ORD_SEL_CHAIN;
        state_d       = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.pt_re  = 1'b1;
        cmd_o.pt_sel = PT_SEL_ORD;
        state_d      = S_RD_C;
      end
      S_RD_C: begin
        if (st_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_point = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  `MWC_ASSERT(a_out_free, cmd_o.out_load |-> st_i.out_free, "result loaded over a held transfer")
  `MWC_ASSERT(a_upd_mode, cmd_o.upd_we |-> !fin_q, "table update during final sweep")
  `MWC_ASSERT_NEXT(a_run_start, accept && op_i == OP_RUN, state_q != S_IDLE, "run did not start")

endmodule

`default_nettype wire

/* rtl/mwc_dpath.sv */
// ----------------------------------------------------------------------------
// mwc_dpath
// point stores, sort order, column table, backtrack and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_weight_monotone_chain_core_macros.svh"

module mwc_dpath #(
  parameter int MAX_POINTS = 1024,
  parameter int COLUMNS    = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mwc_pkg::in_t    in_data_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output mwc_pkg::out_t   out_data_o,
  input  mwc_pkg::cmd_t   cmd_i,
  output mwc_pkg::stat_t  st_o
);
  import mwc_pkg::*;

  localparam int PtW    = $clog2(MAX_POINTS);
  localparam int CntW   = $clog2(MAX_POINTS + 1);
  localparam int CIdxW  = $clog2(COLUMNS);
  localparam int ScoreW = WgtW + CntW;
  localparam logic [CntW-1:0]  NoPoint = CntW'(MAX_POINTS);
  localparam logic [CIdxW-1:0] LastCol = CIdxW'(COLUMNS - 1);

  typedef struct packed {
    logic              present;
    logic [ScoreW-1:0] score;
    logic [CntW-1:0]   pt;
  } tbl_ent_t;

  logic [RowW-1:0] row_mem   [MAX_POINTS];
  logic [ColW-1:0] col_mem   [MAX_POINTS];
  logic [WgtW-1:0] wgt_mem   [MAX_POINTS];
  logic [PtW-1:0]  ord_mem   [MAX_POINTS];
  logic [CntW-1:0] pred_mem  [MAX_POINTS];
  logic [PtW-1:0]  chain_mem [MAX_POINTS];
  tbl_ent_t        tbl_mem   [COLUMNS];

  logic [RowW-1:0]   row_rd_q;
  logic [ColW-1:0]   col_rd_q;
  logic [WgtW-1:0]   wgt_rd_q;
  logic [PtW-1:0]    ord_rd_q;
  logic [CntW-1:0]   pred_rd_q;
  logic [PtW-1:0]    chain_rd_q;
  tbl_ent_t          tbl_rd_q;

  logic [CntW-1:0]   cnt_q, i_q, j_q, rank_q, walk_q, len_q, found_len_q, pick_pt_q;
  logic [RowW-1:0]   key_row_q;
  logic [ColW-1:0]   key_col_q;
  logic [CIdxW-1:0]  col_q, last_q;
  logic [ScoreW-1:0] top_q, best_total_q;
  logic [WgtW-1:0]   w_q;
  logic              ready_q, out_valid_q;
  out_t              out_q;

  logic [CntW-1:0]   i_nx, j_nx, len_m1;
  logic [PtW-1:0]    pt_raddr, ord_raddr;
  logic [CIdxW-1:0]  sat_col, tbl_waddr;
  tbl_ent_t          tbl_wdata;
  logic              key_less, out_free;

  assign i_nx   = i_q + 1'b1;
  assign j_nx   = j_q + 1'b1;
  assign len_m1 = len_q - 1'b1;

  always_comb begin
    unique case (cmd_i.pt_sel)
      PT_SEL_I:   pt_raddr = i_q[PtW-1:0];
      PT_SEL_J:   pt_raddr = j_q[PtW-1:0];
      PT_SEL_ORD: pt_raddr = ord_rd_q;
      default:    pt_raddr = '0;
    endcase
  end

  assign ord_raddr = (cmd_i.ord_sel == ORD_SEL_I) ? i_q[PtW-1:0] : chain_rd_q;

  // columns past the table share its last entry
  assign sat_col = (32'(col_rd_q) > 32'(COLUMNS - 1)) ? LastCol : CIdxW'(col_rd_q);

  // stable order: equal keys fall back to load index
  assign key_less = (row_rd_q < key_row_q) ||
                    ((row_rd_q == key_row_q) &&
                     ((col_rd_q < key_col_q) || ((col_rd_q == key_col_q) && (j_q < i_q))));

  always_comb begin
    if (cmd_i.upd_we) begin
      tbl_waddr         = last_q;
      tbl_wdata.present = 1'b1;
      tbl_wdata.score   = top_q + ScoreW'(w_q);
      tbl_wdata.pt      = i_q;
    end else begin
      tbl_waddr         = col_q;
      tbl_wdata.present = (col_q == '0);
      tbl_wdata.score   = '0;
      tbl_wdata.pt      = NoPoint;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      row_mem[cnt_q[PtW-1:0]] <= in_data_i.row;
      col_mem[cnt_q[PtW-1:0]] <= in_data_i.column;
      wgt_mem[cnt_q[PtW-1:0]] <= in_data_i.weight;
    end
    if (cmd_i.pt_re) begin
      row_rd_q <= row_mem[pt_raddr];
      col_rd_q <= col_mem[pt_raddr];
      wgt_rd_q <= wgt_mem[pt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_we) begin
      ord_mem[rank_q[PtW-1:0]] <= i_q[PtW-1:0];
    end
    if (cmd_i.ord_re) begin
      ord_rd_q <= ord_mem[ord_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_we) begin
      pred_mem[i_q[PtW-1:0]] <= pick_pt_q;
    end
    if (cmd_i.pred_re) begin
      pred_rd_q <= pred_mem[walk_q[PtW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chain_we) begin
      chain_mem[len_m1[PtW-1:0]] <= walk_q[PtW-1:0];
    end
    if (cmd_i.chain_re) begin
      chain_rd_q <= chain_mem[PtW'(in_data_i.position)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_we || cmd_i.tbl_clr_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (cmd_i.tbl_re) begin
      tbl_rd_q <= tbl_mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      rank_q       <= '0;
      col_q        <= '0;
      last_q       <= '0;
      walk_q       <= '0;
      len_q        <= '0;
      found_len_q  <= '0;
      pick_pt_q    <= '0;
      top_q        <= '0;
      best_total_q <= '0;
      ready_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load_pt) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_nx;
      end
      if (cmd_i.j_clr) begin
        j_q    <= '0;
        rank_q <= '0;
      end else begin
        if (cmd_i.j_inc) begin
          j_q <= j_nx;
        end
        if (cmd_i.rank_cmp && key_less) begin
          rank_q <= rank_q + 1'b1;
        end
      end
      if (cmd_i.col_clr || cmd_i.sweep_init) begin
        col_q <= '0;
      end else if (cmd_i.col_inc) begin
        col_q <= col_q + 1'b1;
      end
      // best present score up to the last column, rightmost wins ties
      if (cmd_i.sweep_init) begin
        top_q     <= '0;
        pick_pt_q <= NoPoint;
        last_q    <= cmd_i.sweep_fin ? LastCol : sat_col;
      end else if (cmd_i.sweep_cmp && tbl_rd_q.present && (tbl_rd_q.score >= top_q)) begin
        top_q     <= tbl_rd_q.score;
        pick_pt_q <= tbl_rd_q.pt;
      end
      if (cmd_i.fin_latch) begin
        best_total_q <= top_q;
        walk_q       <= pick_pt_q;
        len_q        <= '0;
      end else if (cmd_i.walk_reset) begin
        found_len_q <= len_q;
        walk_q      <= pick_pt_q;
      end else begin
        if (cmd_i.walk_from_pred) begin
          walk_q <= pred_rd_q;
        end
        if (cmd_i.len_inc) begin
          len_q <= len_q + 1'b1;
        end else if (cmd_i.chain_we) begin
          len_q <= len_m1;
        end
      end
      if (cmd_i.ready_set) begin
        ready_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_latch) begin
      key_row_q <= row_rd_q;
      key_col_q <= col_rd_q;
    end
    if (cmd_i.pt_latch) begin
      w_q <= wgt_rd_q;
    end
    if (cmd_i.out_load) begin
      out_q.status       <= cmd_i.out_status;
      out_q.total_score  <= TotW'(best_total_q);
      out_q.chain_length <= LenW'(found_len_q);
      out_q.point_row    <= cmd_i.out_point ? row_rd_q : '0;
      out_q.point_column <= cmd_i.out_point ? col_rd_q : '0;
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign st_o.full        = (cnt_q == NoPoint);
  assign st_o.cnt_zero    = (cnt_q == '0);
  assign st_o.i_last      = (i_nx == cnt_q);
  assign st_o.j_last      = (j_nx == cnt_q);
  assign st_o.col_last    = (col_q == LastCol);
  assign st_o.col_at_last = (col_q == last_q);
  assign st_o.walk_valid  = (walk_q < cnt_q);
  assign st_o.len_zero    = (len_q == '0);
  assign st_o.ready       = ready_q;
  assign st_o.pos_beyond  = (32'(in_data_i.position) >= 32'(found_len_q));
  assign st_o.out_free    = out_free;

  `MWC_ASSERT(a_cnt_max, cnt_q <= NoPoint, "point count beyond store depth")
  `MWC_ASSERT(a_len_fit, found_len_q <= cnt_q, "chain longer than point count")
  `MWC_ASSERT(a_chain_len, cmd_i.chain_we |-> (len_q != '0), "chain write with no length left")

endmodule

`default_nettype wire

/* rtl/max_weight_monotone_chain_core.sv */
// ----------------------------------------------------------------------------
// max_weight_monotone_chain_core
// loads weighted points, finds the heaviest non-decreasing column chain
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (op, row, column, weight, position)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (status, total, length, point)
//
//  load and unused op: one transfer per cycle while the output is free; a read that
//  returns a point, and a run, hold off new items until they are done
//  a run ranks the points, sweeps the table per point and once more, then walks the chain twice
//  the column table is cleared entry by entry inside each run, no pass after reset
//  a stalled output holds the result; the next item waits until it is taken
// ----------------------------------------------------------------------------
`default_nettype none

module max_weight_monotone_chain_core #(
  parameter int MAX_POINTS = 1024,
  parameter int COLUMNS    = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mwc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mwc_pkg::out_t  out_data_o
);
  import mwc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  mwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.op),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mwc_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .COLUMNS    (COLUMNS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the maximum weight monotone chain core
// ----------------------------------------------------------------------------
// Points are loaded, searches are run and chain points are read back.
// Each accepted input goes into a predictor of the chain search, and each
// result is compared field by field with the oldest prediction. The sender
// works in bursts with gaps, and the receiver stalls in changing patterns.
// Runs are kept on small point stores because a run is slow. The store is
// only filled up at the end, where no further run is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mwc_pkg::*;

  localparam int Depth    = 1024;
  localparam int NumCols  = 1024;
  localparam int NoPoint  = Depth;
  localparam int IdleStop = 3000000;

  // predictor of the chain search plus the queue of predicted results
  class chain_scoreboard;
    logic [RowW-1:0] pt_row[Depth];
    logic [ColW-1:0] pt_col[Depth];
    logic [WgtW-1:0] pt_wgt[Depth];
    int     rank[Depth];
    int     link[Depth];
    int     chain[Depth];
    longint col_score[NumCols];
    int     col_point[NumCols];
    bit     col_seen[NumCols];
    int     count;
    longint total;
    int     length;
    bit     done;
    out_t   due[$];
    int     errors;

    function new();
      count  = 0;
      total  = 0;
      length = 0;
      done   = 0;
      errors = 0;
    endfunction

    function bit key_after(int a, int b);
      if (pt_row[a] != pt_row[b]) return pt_row[a] > pt_row[b];
      return pt_col[a] > pt_col[b];
    endfunction

    // greatest present score in columns 0..last, rightmost on ties
    function int best_col(int last);
      int     pick;
      longint top;
      pick = 0;
      top  = 0;
      for (int c = 0; c <= last; c++) begin
        if (col_seen[c] && col_score[c] >= top) begin
          top  = col_score[c];
          pick = c;
        end
      end
      return pick;
    endfunction

    function void search();
      int j, v, p, c, b, walk, n;
      for (c = 0; c < NumCols; c++) begin
        col_score[c] = 0;
        col_point[c] = NoPoint;
        col_seen[c]  = 0;
      end
      col_seen[0] = 1;
      // stable insertion sort on (row, column)
      for (int i = 0; i < count; i++) begin
        v = i;
        j = i;
        while (j > 0 && key_after(rank[j-1], v)) begin
          rank[j] = rank[j-1];
          j--;
        end
        rank[j] = v;
      end
      for (int i = 0; i < count; i++) begin
        p = rank[i];
        c = int'(pt_col[p]);
        b = best_col(c);
        link[i]      = col_point[b];
        col_score[c] = col_score[b] + pt_wgt[p];
        col_point[c] = i;
        col_seen[c]  = 1;
      end
      b     = best_col(NumCols - 1);
      total = col_score[b];
      n     = 0;
      walk  = col_point[b];
      while (walk < count && n < Depth) begin
        n++;
        walk = link[walk];
      end
      length = n;
      walk   = col_point[b];
      while (n > 0 && walk < count) begin
        n--;
        chain[n] = walk;
        walk     = link[walk];
      end
      done = 1;
    endfunction

    function void note(in_t d);
      out_t r;
      int   idx;
      r = '0;
      r.status = STS_OK;
      case (d.op)
        OP_LOAD: begin
          if (count >= Depth) begin
            r.status = STS_FULL;
          end else begin
            pt_row[count] = d.row;
            pt_col[count] = d.column;
            pt_wgt[count] = d.weight;
            count++;
          end
        end
        OP_RUN: search();
        OP_READ: begin
          if (!done) begin
            r.status = STS_NOT_RUN;
          end else if (int'(d.position) >= length) begin
            r.status = STS_BEYOND;
          end else begin
            idx            = rank[chain[d.position]];
            r.point_row    = pt_row[idx];
            r.point_column = pt_col[idx];
          end
        end
        default: ;
      endcase
      r.total_score  = total[TotW-1:0];
      r.chain_length = length[LenW-1:0];
      due.insert(due.size(), r);
    endfunction

    function void check(out_t got);
      out_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = due.pop_front();
      if (got.status != e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.total_score != e.total_score) begin
        $display("%0t: total_score expected %0d actual %0d", $time,
                 e.total_score, got.total_score);
        errors++;
      end
      if (got.chain_length != e.chain_length) begin
        $display("%0t: chain_length expected %0d actual %0d", $time,
                 e.chain_length, got.chain_length);
        errors++;
      end
      if (got.point_row != e.point_row) begin
        $display("%0t: point_row expected %0d actual %0d", $time,
                 e.point_row, got.point_row);
        errors++;
      end
      if (got.point_column != e.point_column) begin
        $display("%0t: point_column expected %0d actual %0d", $time,
                 e.point_column, got.point_column);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  chain_scoreboard sb = new();
  int burst_left;
  int idle_cycles;
  int stall_mode;
  int mode_left;

  max_weight_monotone_chain_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver: checks each transfer, stalls in modes, and guards against hangs
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check(out_data_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleStop) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(8, 80);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send(in_t d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due.size() > 0) @(posedge clk_i);
  endtask

  task automatic put(op_e op, int r, int c, int w, int pos);
    in_t d;
    d.op       = op;
    d.row      = RowW'(r);
    d.column   = ColW'(c);
    d.weight   = WgtW'(w);
    d.position = PosW'(pos);
    send(d);
  endtask

  function automatic int pick_column();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, NumCols - 1);
    return $urandom_range(0, 31);
  endfunction

  function automatic int pick_row();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 7);
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic load_random();
    put(OP_LOAD, pick_row(), pick_column(), pick_weight(), $urandom_range(0, 1023));
  endtask

  task automatic read_random();
    int pos;
    if ($urandom_range(0, 5) == 0) pos = $urandom_range(0, 1023);
    else pos = $urandom_range(0, sb.length + 1);
    if (pos > 1023) pos = 1023;
    put(OP_READ, $urandom_range(0, 65535), $urandom_range(0, 1023),
        $urandom_range(0, 65535), pos);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    burst_left  = 0;
    idle_cycles = 0;
    stall_mode  = 0;
    mode_left   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: read before any run, unused op, empty run, edge values
    put(OP_READ, 0, 0, 0, 0);
    put(OP_NONE, 65535, 1023, 65535, 1023);
    put(OP_RUN, 0, 0, 0, 0);
    put(OP_READ, 0, 0, 0, 0);
    put(OP_LOAD, 0, 0, 0, 0);
    put(OP_LOAD, 65535, 1023, 65535, 0);
    put(OP_LOAD, 5, 3, 100, 0);
    put(OP_LOAD, 5, 3, 100, 0);
    put(OP_LOAD, 5, 1, 7, 0);
    put(OP_LOAD, 2, 1023, 1, 0);
    put(OP_LOAD, 2, 0, 65535, 0);
    put(OP_RUN, 0, 0, 0, 0);
    for (int p = 0; p < 8; p++) put(OP_READ, 0, 0, 0, p);
    put(OP_READ, 0, 0, 0, 1023);
    put(OP_LOAD, 1, 2, 3, 0);
    put(OP_READ, 0, 0, 0, 0);

    // random: small stores with a run each, then many reads
    for (int ph = 0; ph < 26; ph++) begin
      repeat ($urandom_range(1, 6)) load_random();
      if ($urandom_range(0, 3) == 0) drain();
      put(OP_RUN, $urandom_range(0, 65535), $urandom_range(0, 1023),
          $urandom_range(0, 65535), $urandom_range(0, 1023));
      repeat ($urandom_range(6, 18)) begin
        if ($urandom_range(0, 15) == 0)
          put(OP_NONE, $urandom_range(0, 65535), $urandom_range(0, 1023),
              $urandom_range(0, 65535), $urandom_range(0, 1023));
        else read_random();
      end
    end

    // fill the store past its end; the old result stays readable
    drain();
    while (sb.count < Depth + 8) begin
      if ($urandom_range(0, 7) == 0) read_random();
      else load_random();
      if (sb.count == Depth) begin
        repeat (4) load_random();
        break;
      end
    end
    repeat (20) read_random();

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
